@@ rtl/audio_fir_convolver_defines.svh @@
// ----------------------------------------------------------------------------
// Audio FIR convolver assertion macros
// Shared concurrent-assertion shorthands, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef AUDIO_FIR_CONVOLVER_DEFINES_SVH
`define AUDIO_FIR_CONVOLVER_DEFINES_SVH

// Same-cycle implication.
`define AFC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("audio_fir_convolver: same-cycle check failed");

// Next-cycle implication.
`define AFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("audio_fir_convolver: next-cycle check failed");

`endif

@@ rtl/afc_pkg.sv @@
// ----------------------------------------------------------------------------
// Audio FIR convolver package
// Payload types, op codes, saturation limits and MAC control struct.
// ----------------------------------------------------------------------------
package afc_pkg;

  typedef logic signed [15:0] sample_t;
  typedef logic [5:0]         tap_index_t;
  typedef logic [6:0]         num_taps_t;
  typedef logic [1:0]         op_t;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_FLUSH  = 2'd2
  } afc_op_e;

  localparam int        FRAC_BITS    = 15;
  localparam sample_t   SAT_MAX      = 16'sh7FFF;
  localparam sample_t   SAT_MIN      = 16'sh8000;
  localparam num_taps_t NUM_TAPS_RST = 7'd1;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;  // zero the accumulator
    logic feed;   // tap/sample operands are valid this cycle
    logic keep;   // sample lies inside the filled history, else counts as zero
  } mac_ctrl_t;

endpackage

@@ rtl/afc_in_if.sv @@
// ----------------------------------------------------------------------------
// Audio FIR convolver input channel
// Valid/ready channel carrying one op with its tap index and sample value.
// ----------------------------------------------------------------------------
interface afc_in_if;
  logic               valid;
  logic               ready;
  afc_pkg::op_t       op;
  afc_pkg::tap_index_t tap_index;
  afc_pkg::sample_t   sample_value;

  modport source (output valid, output op, output tap_index, output sample_value,
                  input ready);
  modport sink   (input valid, input op, input tap_index, input sample_value,
                  output ready);
endinterface

@@ rtl/afc_out_if.sv @@
// ----------------------------------------------------------------------------
// Audio FIR convolver output channel
// Valid/ready channel carrying one output sample and the end-of-tail flag.
// ----------------------------------------------------------------------------
interface afc_out_if;
  logic             valid;
  logic             ready;
  afc_pkg::sample_t out_sample;
  logic             last_of_tail;

  modport source (output valid, output out_sample, output last_of_tail, input ready);
  modport sink   (input valid, input out_sample, input last_of_tail, output ready);
endinterface

@@ rtl/afc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Audio FIR convolver configuration channel
// Valid/ready write channel for the tap count register.
// ----------------------------------------------------------------------------
interface afc_cfg_if;
  logic                valid;
  logic                ready;
  afc_pkg::num_taps_t  num_taps;

  modport source (output valid, output num_taps, input ready);
  modport sink   (input valid, input num_taps, output ready);
endinterface

@@ rtl/afc_mac.sv @@
// ----------------------------------------------------------------------------
// Audio FIR convolver multiply-accumulate unit
// One registered 16x16 product per cycle into a wide accumulator, Q15 output.
// ----------------------------------------------------------------------------
module afc_mac #(
  parameter int ACC_W = 38
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  afc_pkg::mac_ctrl_t  ctrl_i,
  input  afc_pkg::sample_t    tap_i,
  input  afc_pkg::sample_t    smp_i,
  output logic                busy_o,
  output afc_pkg::sample_t    result_o
);
  import afc_pkg::*;

  localparam logic signed [ACC_W-1:0] ONE_Q30  = ACC_W'(64'sd1 << (2 * FRAC_BITS));
  localparam logic signed [ACC_W-1:0] ROUND_TZ = ACC_W'((64'sd1 << FRAC_BITS) - 64'sd1);

  logic signed [31:0]      prod_q;
  logic                    feed_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] acc_adj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feed_q <= 1'b0;
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      feed_q <= ctrl_i.feed;
      if (ctrl_i.feed) begin
        prod_q <= ctrl_i.keep ? tap_i * smp_i : 32'sd0;
      end
      if (ctrl_i.clear) begin
        acc_q <= '0;
      end else if (feed_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  // Bias negatives so the arithmetic shift truncates toward zero.
  assign acc_adj = acc_q + (acc_q[ACC_W-1] ? ROUND_TZ : '0);

  always_comb begin
    priority if (acc_q >= ONE_Q30) begin
      result_o = SAT_MAX;
    end else if (acc_q < -ONE_Q30) begin
      result_o = SAT_MIN;
    end else begin
      result_o = acc_adj[FRAC_BITS +: 16];
    end
  end

  assign busy_o = feed_q;

endmodule

@@ rtl/audio_fir_convolver.sv @@
// ----------------------------------------------------------------------------
// Audio FIR convolver
// Direct-form FIR: full linear convolution of 16-bit audio with loaded taps.
// ----------------------------------------------------------------------------
// Usage: load the impulse response with load-tap items (op 0, one tap per
// transfer), set the tap count N on the configuration channel, then send
// samples (op 1); every sample returns one output, the Q15 sum of tap[m] times
// sample[n-m] over N terms, truncated toward zero and saturated to 16 bits.
// A flush item (op 2) returns the N-1 tail outputs, flags the last with
// last_of_tail and leaves the history cleared; with N of 1 it returns nothing.
// One shared multiply-accumulate unit walks the taps one per cycle: each
// issue step reads one tap and one sample, the last product is then formed
// and added, and the output is registered; a flush repeats this walk for
// each tail output. Load items and unused op codes return no output.
// The input stays not-ready while a sum is being formed; a finished output
// sits in its own register, so the next item is accepted while it waits.
// The history is not swept at reset or flush: a fill count marks how many
// recent slots are live and older slots read as zero.
// ----------------------------------------------------------------------------
`include "audio_fir_convolver_defines.svh"

module audio_fir_convolver #(
  parameter int MAX_TAPS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  afc_cfg_if.sink   cfg_i,
  afc_in_if.sink    in_i,
  afc_out_if.source out_o
);
  import afc_pkg::*;

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int CW    = $clog2(MAX_TAPS + 1);
  localparam int ACC_W = 32 + $clog2(MAX_TAPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN
  } state_e;

  // Tap and history memories, no reset.
  sample_t tap_mem  [MAX_TAPS];
  sample_t hist_mem [MAX_TAPS];
  sample_t tap_rd_q;
  sample_t hist_rd_q;

  state_e          state_q;
  logic [AW-1:0]   ptr_q;      // next history write slot
  logic [CW-1:0]   fill_q;     // live history slots since reset or flush
  num_taps_t       num_taps_q;
  logic [CW-1:0]   cnt_q;      // taps in use for the current item
  logic [CW-1:0]   tail_q;     // tail outputs still owed, current one included
  logic            is_flush_q;
  logic [AW-1:0]   m_q;        // tap being issued
  logic [AW-1:0]   rd_q;       // history slot being issued
  logic            s1_q;       // read data valid
  logic            keep1_q;
  logic            out_valid_q;
  sample_t         out_sample_q;
  logic            out_last_q;

  logic            in_take;
  logic            cfg_take;
  logic [CW-1:0]   count_use;
  logic [AW-1:0]   ptr_inc;
  logic [AW-1:0]   rd_dec;
  logic [CW-1:0]   fill_inc;
  logic            issue;
  logic            last_issue;
  logic            more_tail;
  logic            out_free;
  logic            emit;
  logic            tap_we;
  logic            hist_we;
  sample_t         hist_wd;
  mac_ctrl_t       mac_ctrl;
  logic            mac_busy;
  sample_t         mac_result;

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_take     = in_i.valid && in_i.ready;
  assign cfg_take    = cfg_i.valid && cfg_i.ready;

  assign out_o.valid        = out_valid_q;
  assign out_o.out_sample   = out_sample_q;
  assign out_o.last_of_tail = out_last_q;

  // Tap count in use: zero acts as one, anything past the store acts as full.
  always_comb begin
    priority if (num_taps_q == '0) begin
      count_use = CW'(1);
    end else if (int'(num_taps_q) > MAX_TAPS) begin
      count_use = CW'(MAX_TAPS);
    end else begin
      count_use = CW'(num_taps_q);
    end
  end

  // Circular history pointers.
  assign ptr_inc  = (ptr_q == AW'(MAX_TAPS - 1)) ? '0 : ptr_q + AW'(1);
  assign rd_dec   = (rd_q == '0) ? AW'(MAX_TAPS - 1) : rd_q - AW'(1);
  assign fill_inc = (fill_q == CW'(MAX_TAPS)) ? fill_q : fill_q + CW'(1);

  assign issue      = (state_q == ST_MAC);
  assign last_issue = issue && (CW'(m_q) == cnt_q - CW'(1));
  assign more_tail  = (tail_q > CW'(1));
  assign out_free   = !out_valid_q || out_o.ready;
  assign emit       = (state_q == ST_DRAIN) && !s1_q && !mac_busy && out_free;

  // Tap loads beyond the store are dropped.
  assign tap_we = in_take && (in_i.op == OP_LOAD) && (int'(in_i.tap_index) < MAX_TAPS);

  // Every push into the history restarts the MAC walk: a sample, the first
  // zero of a flush with more than one tap, and each further tail zero.
  always_comb begin
    hist_we = 1'b0;
    hist_wd = '0;
    if (in_take && (in_i.op == OP_SAMPLE)) begin
      hist_we = 1'b1;
      hist_wd = in_i.sample_value;
    end else if (in_take && (in_i.op == OP_FLUSH) && (count_use != CW'(1))) begin
      hist_we = 1'b1;
    end else if (emit && is_flush_q && more_tail) begin
      hist_we = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (tap_we) begin
      tap_mem[AW'(in_i.tap_index)] <= in_i.sample_value;
    end
    tap_rd_q <= tap_mem[m_q];
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[ptr_q] <= hist_wd;
    end
    hist_rd_q <= hist_mem[rd_q];
  end

  // --------------------------------------------------------------------------
  // Shared multiply-accumulate
  // --------------------------------------------------------------------------
  assign mac_ctrl.clear = hist_we;
  assign mac_ctrl.feed  = s1_q;
  assign mac_ctrl.keep  = keep1_q;

  afc_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .tap_i    (tap_rd_q),
    .smp_i    (hist_rd_q),
    .busy_o   (mac_busy),
    .result_o (mac_result)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ptr_q        <= '0;
      fill_q       <= '0;
      num_taps_q   <= NUM_TAPS_RST;
      cnt_q        <= CW'(1);
      tail_q       <= '0;
      is_flush_q   <= 1'b0;
      m_q          <= '0;
      rd_q         <= '0;
      s1_q         <= 1'b0;
      keep1_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      out_sample_q <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (cfg_take) begin
        num_taps_q <= cfg_i.num_taps;
      end
      s1_q    <= issue;
      keep1_q <= (CW'(m_q) < fill_q);
      // Drop the output once taken, unless a new one replaces it this cycle.
      if (out_valid_q && out_o.ready && !emit) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            cnt_q <= count_use;
            unique case (in_i.op)
              OP_SAMPLE: begin
                is_flush_q <= 1'b0;
              end
              OP_FLUSH: begin
                is_flush_q <= 1'b1;
                tail_q     <= count_use - CW'(1);
                // Single tap: nothing to emit, clear the history now.
                if (count_use == CW'(1)) begin
                  ptr_q  <= '0;
                  fill_q <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_MAC: begin
          m_q  <= m_q + AW'(1);
          rd_q <= rd_dec;
          if (last_issue) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (emit) begin
            out_valid_q  <= 1'b1;
            out_sample_q <= mac_result;
            out_last_q   <= is_flush_q && !more_tail;
            if (is_flush_q && more_tail) begin
              tail_q <= tail_q - CW'(1);
            end else begin
              state_q <= ST_IDLE;
              if (is_flush_q) begin
                ptr_q  <= '0;
                fill_q <= '0;
              end
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // Push into the history and start a new walk from the newest sample.
      if (hist_we) begin
        ptr_q   <= ptr_inc;
        fill_q  <= fill_inc;
        rd_q    <= ptr_q;
        m_q     <= '0;
        state_q <= ST_MAC;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `AFC_ASSERT_IMPL(a_idle_pipe_empty, state_q == ST_IDLE, !s1_q && !mac_busy)
  `AFC_ASSERT_IMPL(a_issue_in_range, state_q == ST_MAC, CW'(m_q) < cnt_q)
  `AFC_ASSERT_NEXT(a_last_clears, emit && is_flush_q && !more_tail, ptr_q == '0 && fill_q == '0 && state_q == ST_IDLE)

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Audio FIR convolver testbench
// Drives load, sample, flush and unused-op transfers through the input
// channel and sets the tap count between phases. A bit-exact FIR predictor
// forms the expected outputs, and each returned sample is compared in order.
// ----------------------------------------------------------------------------
module tb_top;
  import afc_pkg::*;

  localparam int     MAX_TAPS     = 64;
  localparam int     CLK_HALF     = 6;
  localparam int     DRAIN_CYCLES = 200;     // > two 64-tap sums with margin
  localparam int     CYCLE_LIMIT  = 4000000;
  localparam int     SHOWN_ERRORS = 10;
  localparam longint Q30_ONE      = 64'sd1 << 30;
  localparam op_t    OP_UNUSED    = 2'd3;    // no operation behind this code

  typedef struct packed {
    op_t        op;
    tap_index_t tap_index;
    sample_t    value;
  } fir_item_t;

  typedef struct packed {
    sample_t out_sample;
    logic    last_of_tail;
  } fir_out_t;

  logic clk_i;
  logic rst_ni;

  afc_cfg_if cfg_ch ();
  afc_in_if  in_ch ();
  afc_out_if out_ch ();

  audio_fir_convolver #(
    .MAX_TAPS (MAX_TAPS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Predictor state: taps, sample history ring, write slot and tap count.
  sample_t    coef_bank [MAX_TAPS];
  sample_t    hist_buf  [MAX_TAPS];
  tap_index_t hist_wr;
  num_taps_t  model_num_taps;

  fir_item_t  pending_items[$];
  fir_out_t   expected_outputs[$];
  fir_item_t  cur_item;
  bit         in_transit;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         error_count;
  int         cycle_count;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #(CLK_HALF) clk_i = ~clk_i;
  end

  // A count of zero behaves as one tap, anything above the bank as the full bank.
  function automatic int taps_in_use();
    if (model_num_taps == '0) return 1;
    if (int'(model_num_taps) > MAX_TAPS) return MAX_TAPS;
    return int'(model_num_taps);
  endfunction

  // Push one sample into the history and return the saturated Q15 sum.
  function automatic sample_t fir_push_sample(sample_t x);
    longint acc;
    int     count;
    int     m;
    int     slot;
    acc   = 0;
    count = taps_in_use();
    hist_buf[hist_wr] = x;
    for (m = 0; m < count; m++) begin
      slot = (int'(hist_wr) - m + MAX_TAPS) % MAX_TAPS;
      acc += longint'(coef_bank[m]) * longint'(hist_buf[slot]);
    end
    hist_wr = hist_wr + 1'b1;
    // Exactly +1.0 already saturates; the negative side keeps -1.0 itself.
    if (acc >= Q30_ONE) return SAT_MAX;
    if (acc < -Q30_ONE) return SAT_MIN;
    return sample_t'(acc / (64'sd1 << FRAC_BITS));
  endfunction

  // Update the predictor for one accepted transfer and queue its outputs.
  function automatic void apply_item(fir_item_t item);
    int       tail;
    int       k;
    fir_out_t res;
    case (item.op)
      OP_LOAD: begin
        coef_bank[item.tap_index] = item.value;
      end
      OP_SAMPLE: begin
        res.out_sample   = fir_push_sample(item.value);
        res.last_of_tail = 1'b0;
        expected_outputs.push_back(res);
      end
      OP_FLUSH: begin
        tail = taps_in_use() - 1;
        for (k = 0; k < tail; k++) begin
          res.out_sample   = fir_push_sample('0);
          res.last_of_tail = (k == tail - 1);
          expected_outputs.push_back(res);
        end
        // Drop the whole history, including the zeros fed for the tail.
        for (k = 0; k < MAX_TAPS; k++) hist_buf[k] = '0;
        hist_wr = '0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= SHOWN_ERRORS) $display("%0t: %s", $realtime, msg);
  endfunction

  // Mostly uniform values, with the extremes and tiny values mixed in.
  function automatic sample_t pick_value();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 70) return sample_t'($urandom_range(65535, 0));
    if (pick < 85) begin
      case ($urandom_range(4, 0))
        0:       return SAT_MAX;
        1:       return SAT_MIN;
        2:       return 16'sd1;
        3:       return -16'sd1;
        default: return '0;
      endcase
    end
    return sample_t'($urandom_range(40, 0) - 20);
  endfunction

  function automatic void queue_item(op_t op, tap_index_t idx, sample_t value);
    fir_item_t item;
    item.op        = op;
    item.tap_index = idx;
    item.value     = value;
    pending_items.push_back(item);
  endfunction

  // Input driver: advance the queue, predict at the edge a transfer happens.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_item(cur_item);
        in_transit = 1'b0;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          cur_item   = pending_items.pop_front();
          in_transit = 1'b1;
          in_ch.valid        <= 1'b1;
          in_ch.op           <= cur_item.op;
          in_ch.tap_index    <= cur_item.tap_index;
          in_ch.sample_value <= cur_item.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each transfer against the oldest expectation.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_outputs.size() == 0) begin
          note_error($sformatf("unexpected output sample %0d last %0b",
                               out_ch.out_sample, out_ch.last_of_tail));
        end else begin
          automatic fir_out_t want = expected_outputs.pop_front();
          if (out_ch.out_sample !== want.out_sample)
            note_error($sformatf("out_sample expected %0d got %0d",
                                 want.out_sample, out_ch.out_sample));
          if (out_ch.last_of_tail !== want.last_of_tail)
            note_error($sformatf("last_of_tail expected %0b got %0b",
                                 want.last_of_tail, out_ch.last_of_tail));
        end
      end
      out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Hold until every item has gone in and every output has come back, then
  // let the block finish any work that produces no output.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_transit || expected_outputs.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the tap count; call only right after a rising edge while idle.
  task automatic write_num_taps(num_taps_t count);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.num_taps <= count;
    do @(posedge clk_i);
    while (!cfg_ch.ready);
    cfg_ch.valid   <= 1'b0;
    model_num_taps = count;
  endtask

  // One random phase: mostly samples over the loaded response, with tap
  // rewrites, flushes and some unused-op noise.
  task automatic queue_random_phase(int items);
    int done;
    int pick;
    done = 0;
    while (done < items) begin
      pick = $urandom_range(99, 0);
      if (pick < 4) begin
        queue_item(OP_UNUSED, tap_index_t'($urandom_range(63, 0)), pick_value());
      end else begin
        done++;
        if (pick < 16)
          queue_item(OP_LOAD, tap_index_t'($urandom_range(63, 0)), pick_value());
        else if (pick < 23)
          queue_item(OP_FLUSH, tap_index_t'($urandom_range(63, 0)), pick_value());
        else
          queue_item(OP_SAMPLE, tap_index_t'($urandom_range(63, 0)), pick_value());
      end
    end
  endtask

  num_taps_t phase_taps [6] = '{7'd3, 7'd16, 7'd64, 7'd2, 7'd100, 7'd9};

  initial begin
    int i;
    // Known values on every input from time zero.
    rst_ni          = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.num_taps = NUM_TAPS_RST;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_LOAD;
    in_ch.tap_index    = '0;
    in_ch.sample_value = '0;
    out_ch.ready    = 1'b0;
    in_transit      = 1'b0;
    error_count     = 0;
    cycle_count     = 0;
    send_idle_pct   = 17;
    recv_idle_pct   = 53;
    for (i = 0; i < MAX_TAPS; i++) begin
      coef_bank[i] = '0;
      hist_buf[i]  = '0;
    end
    hist_wr        = '0;
    model_num_taps = NUM_TAPS_RST;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Count zero acts as a single tap. Fill the whole bank first so that
    // no unwritten tap is ever read, whatever count comes later.
    write_num_taps(7'd0);
    for (i = 0; i < MAX_TAPS; i++) queue_item(OP_LOAD, tap_index_t'(i), pick_value());
    queue_item(OP_LOAD, 6'd0, SAT_MIN);
    queue_item(OP_SAMPLE, 6'd0, SAT_MIN);       // exactly +1.0: saturates high
    queue_item(OP_SAMPLE, 6'd63, SAT_MAX);
    queue_item(OP_SAMPLE, 6'd0, 16'sd0);
    queue_item(OP_UNUSED, 6'd63, SAT_MAX);      // ignored, no output
    queue_item(OP_FLUSH, 6'd0, 16'sd0);         // single tap: no output, clears history
    queue_item(OP_SAMPLE, 6'd21, 16'sd1);
    queue_item(OP_SAMPLE, 6'd42, -16'sd5);
    wait_idle();

    // Count above the bank acts as the full bank; drive the sum below -1.0.
    write_num_taps(7'd127);
    queue_item(OP_LOAD, 6'd0, SAT_MAX);
    queue_item(OP_LOAD, 6'd1, SAT_MAX);
    queue_item(OP_LOAD, 6'd63, -16'sd1);
    queue_item(OP_SAMPLE, 6'd0, SAT_MIN);
    queue_item(OP_SAMPLE, 6'd0, SAT_MIN);
    queue_item(OP_SAMPLE, 6'd0, SAT_MAX);
    queue_item(OP_SAMPLE, 6'd0, -16'sd7);
    queue_item(OP_FLUSH, 6'd0, 16'sd0);         // 63 tail outputs
    queue_item(OP_SAMPLE, 6'd0, 16'sd3);
    wait_idle();

    // Random phases under changing counts; every two phases the idle pattern is swapped, then turned off.
    for (i = 0; i < 6; i++) begin
      if (i == 2) begin
        send_idle_pct = 53;
        recv_idle_pct = 17;
      end else if (i == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_num_taps(phase_taps[i]);
      queue_random_phase(5);
      wait_idle();
    end

    if (expected_outputs.size() != 0)
      note_error($sformatf("%0d expected outputs never arrived", expected_outputs.size()));
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
